>>> design/ldlcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED driver latch command decoder package
// Shared widths, command codes and the front-to-back request record.
// ----------------------------------------------------------------------------
package ldlcd_pkg;

  localparam int SLOTS       = 16;
  localparam int WORD_BITS   = 48;
  localparam int ADDR_ORIGIN = 15;
  localparam int COLOUR_BITS = 16;
  localparam int POKER_BIT   = 44;
  localparam int XREF_BIT    = 5;
  localparam int ESPWM_BIT   = 8;
  localparam int LAT_BITS    = 5;
  localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_WRTGS   = 4'd1,
    CMD_LATGS   = 4'd2,
    CMD_WRTFC   = 4'd3,
    CMD_LINERST = 4'd4,
    CMD_READFC  = 4'd5,
    CMD_TMGRST  = 4'd6,
    CMD_FCWRTEN = 4'd7,
    CMD_INVALID = 4'd8
  } cmd_t;

  // One classified beat handed from the front to the back.
  typedef struct packed {
    cmd_t         cmd;
    word_t        word;
    logic [5:0]   view;
  } req_t;

  function automatic cmd_t decode_len(input logic [LAT_BITS-1:0] len);
    cmd_t c;
    case (len)
      5'd0:    c = CMD_NONE;
      5'd1:    c = CMD_WRTGS;
      5'd3:    c = CMD_LATGS;
      5'd5:    c = CMD_WRTFC;
      5'd7:    c = CMD_LINERST;
      5'd11:   c = CMD_READFC;
      5'd13:   c = CMD_TMGRST;
      5'd15:   c = CMD_FCWRTEN;
      default: c = CMD_INVALID;
    endcase
    return c;
  endfunction

endpackage

>>> design/ldlcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Shifts serial data, measures the latch pulse and classifies the command.
// ----------------------------------------------------------------------------
module ldlcd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           serial_bit,
  input  wire logic           latch_level,
  input  wire logic [5:0]     view_word,
  output ldlcd_pkg::req_t     req
);

  ldlcd_pkg::word_t                  shift_word;
  logic [ldlcd_pkg::LAT_BITS-1:0]    latch_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word   <= '0;
      latch_length <= '0;
    end else if (in_valid) begin
      shift_word <= {shift_word[ldlcd_pkg::WORD_BITS-2:0], serial_bit};
      if (latch_level) begin
        if (latch_length != '1) latch_length <= latch_length + 1'b1;
      end else begin
        latch_length <= '0;
      end
    end
  end

  // The command acts on the shift word as it stood before this beat's bit.
  always_comb begin
    req.cmd  = latch_level ? ldlcd_pkg::CMD_NONE : ldlcd_pkg::decode_len(latch_length);
    req.word = shift_word;
    req.view = view_word;
  end

endmodule
`default_nettype wire

>>> design/ldlcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module ldlcd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire ldlcd_pkg::req_t wdata,
  output logic                 full,
  input  wire logic            rd,
  output ldlcd_pkg::req_t      rdata,
  output logic                 empty
);

  ldlcd_pkg::req_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");

endmodule
`default_nettype wire

>>> design/ldlcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Executes commands on the banks and counters and holds one result beat.
// ----------------------------------------------------------------------------
module ldlcd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire ldlcd_pkg::req_t req,
  output logic                 req_take,
  input  wire logic            pop,
  output logic                 empty,
  output logic [3:0]           command_done,
  output logic                 mode_conflict,
  output logic [47:0]          control_word,
  output logic [3:0]           slot_address,
  output logic [15:0]          line_count,
  output logic [15:0]          display_word
);

  localparam int S = ldlcd_pkg::SLOTS;
  localparam int W = ldlcd_pkg::WORD_BITS;
  localparam logic [3:0] ORIGIN = 4'(ldlcd_pkg::ADDR_ORIGIN);

  ldlcd_pkg::word_t staging_bank [S];
  ldlcd_pkg::word_t display_bank [S];
  ldlcd_pkg::word_t staging_next [S];
  ldlcd_pkg::word_t control_reg;
  logic [3:0]       address_counter;
  logic [15:0]      line_counter;
  ldlcd_pkg::word_t control_next;
  logic [3:0]       address_next;
  logic [15:0]      line_next;
  logic             do_store;
  logic             do_copy;
  logic             out_valid;
  logic [15:0]      dword;
  logic [11:0]      vprod;
  logic [5:0]       vslot;
  logic [1:0]       vcol;

  // Output register is free or being drained this cycle.
  assign req_take = req_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    do_store     = (req.cmd == ldlcd_pkg::CMD_WRTGS) || (req.cmd == ldlcd_pkg::CMD_LATGS) ||
                   (req.cmd == ldlcd_pkg::CMD_LINERST);
    do_copy      = (req.cmd == ldlcd_pkg::CMD_LATGS) || (req.cmd == ldlcd_pkg::CMD_LINERST);
    control_next = control_reg;
    address_next = address_counter;
    line_next    = line_counter;
    case (req.cmd)
      ldlcd_pkg::CMD_WRTGS:   address_next = address_counter - 4'd1;
      ldlcd_pkg::CMD_LATGS: begin
        address_next = ORIGIN;
        line_next    = line_counter + 16'd1;
      end
      ldlcd_pkg::CMD_WRTFC: begin
        control_next = req.word;
        address_next = ORIGIN;
      end
      ldlcd_pkg::CMD_LINERST, ldlcd_pkg::CMD_TMGRST: begin
        address_next = ORIGIN;
        line_next    = '0;
      end
      default: ;
    endcase
  end

  // Normal store writes one slot; poker store scatters one bit per colour word.
  always_comb begin
    for (int s = 0; s < S; s++) begin
      staging_next[s] = staging_bank[s];
      if (do_store) begin
        if (!control_reg[ldlcd_pkg::POKER_BIT]) begin
          if (32'(address_counter) == s) staging_next[s] = req.word;
        end else begin
          for (int j = 0; j < 3; j++) begin
            if (3 * s + 2 - j < W)
              staging_next[s][6'(32 + 32'(address_counter) - 16 * j)] = req.word[3 * s + 2 - j];
            else
              staging_next[s][6'(32 + 32'(address_counter) - 16 * j)] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < S; s++) begin
        staging_bank[s] <= '0;
        display_bank[s] <= '0;
      end
      control_reg     <= '0;
      address_counter <= ORIGIN;
      line_counter    <= '0;
    end else if (req_take) begin
      for (int s = 0; s < S; s++) begin
        staging_bank[s] <= staging_next[s];
        if (do_copy) display_bank[s] <= staging_next[s];
      end
      control_reg     <= control_next;
      address_counter <= address_next;
      line_counter    <= line_next;
    end
  end

  // View read uses the bank after this beat's command. The slot is the view
  // divided by three, taken as a multiply by 43/128, which is exact for 0..63.
  always_comb begin
    vprod = 12'(req.view) * 12'd43;
    vslot = {1'b0, vprod[11:7]};
    vcol  = 2'(req.view - vslot * 6'd3);
    dword = '0;
    for (int s = 0; s < S; s++) begin
      if (32'(vslot) == s) begin
        case (vcol)
          2'd0:    dword = do_copy ? staging_next[s][15:0]  : display_bank[s][15:0];
          2'd1:    dword = do_copy ? staging_next[s][31:16] : display_bank[s][31:16];
          2'd2:    dword = do_copy ? staging_next[s][47:32] : display_bank[s][47:32];
          default: dword = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      command_done  <= req.cmd;
      mode_conflict <= control_next[ldlcd_pkg::POKER_BIT] &&
                       (!control_next[ldlcd_pkg::XREF_BIT] || !control_next[ldlcd_pkg::ESPWM_BIT]);
      control_word  <= control_next;
      slot_address  <= address_next;
      line_count    <= line_next;
      display_word  <= dword;
    end
  end

  assert property (@(posedge clk) disable iff (rst) req_take |=> out_valid)
    else $error("taken request left no result");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !pop) |=> $stable(command_done))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst)
                   (req_take && req.cmd == ldlcd_pkg::CMD_TMGRST) |=> line_counter == 16'd0)
    else $error("timing reset left line count");

endmodule
`default_nettype wire

>>> design/led_driver_latch_command_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a pushed item passes through the queue and then the result register.
// Throughput: one item per cycle while the consumer pops; the front and back are parted by a two-entry
// queue and the result register, so each side stalls on its own.
// Reset: synchronous; banks, counters and control clear, address goes to origin.
// ----------------------------------------------------------------------------
// LED driver latch command decoder
// Serial shift, latch pulse decode and grayscale bank update.
// ----------------------------------------------------------------------------
module led_driver_latch_command_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        serial_bit,
  input  wire logic        latch_level,
  input  wire logic [5:0]  view_word,
  input  wire logic        pop,
  output logic             empty,
  output logic [3:0]       command_done,
  output logic             mode_conflict,
  output logic [47:0]      control_word,
  output logic [3:0]       slot_address,
  output logic [15:0]      line_count,
  output logic [15:0]      display_word
);

  ldlcd_pkg::req_t front_req;
  ldlcd_pkg::req_t back_req;
  logic            q_empty;
  logic            take;
  logic            accept;

  assign accept = push && !full;

  ldlcd_front u_front (
    .clk(clk), .rst(rst), .in_valid(accept), .serial_bit(serial_bit),
    .latch_level(latch_level), .view_word(view_word), .req(front_req)
  );

  ldlcd_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(front_req), .full(full),
    .rd(take), .rdata(back_req), .empty(q_empty)
  );

  ldlcd_back u_back (
    .clk(clk), .rst(rst), .req_valid(!q_empty), .req(back_req), .req_take(take),
    .pop(pop), .empty(empty), .command_done(command_done),
    .mode_conflict(mode_conflict), .control_word(control_word),
    .slot_address(slot_address), .line_count(line_count), .display_word(display_word)
  );

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED driver latch command decoder testbench
// Drives serial bits and latch pulses of every command length and of invalid lengths, predicts each result
// beat from an independent model of the banks and counters, and checks them.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [3:0]  cmd;
    logic        conflict;
    logic [47:0] ctl;
    logic [3:0]  addr;
    logic [15:0] lines;
    logic [15:0] dword;
  } status_t;

  typedef struct {
    logic       sbit;
    logic       lat;
    logic [5:0] view;
    logic       has_exp;
    status_t    exp;
  } row_t;

  localparam int LIMIT = 200000;

  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic serial_bit = 0, latch_level = 0;
  logic [5:0] view_word = 0;
  wire full, empty, mode_conflict;
  wire [3:0] command_done, slot_address;
  wire [47:0] control_word;
  wire [15:0] line_count, display_word;

  led_driver_latch_command_decoder_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state.
  ldlcd_pkg::word_t shreg;
  logic [4:0]       pulse_len;
  ldlcd_pkg::word_t stage [ldlcd_pkg::SLOTS];
  ldlcd_pkg::word_t shown [ldlcd_pkg::SLOTS];
  ldlcd_pkg::word_t fctl;
  logic [3:0]       gs_addr;
  logic [15:0]      lines;

  status_t status_q[$];
  int errors = 0, beats_in = 0, beats_out = 0, cycles = 0;
  int cmd_seen [9];
  int pop_hold = 0;
  bit calm = 0;

  function automatic void model_reset();
    shreg = '0; pulse_len = '0; fctl = '0; lines = '0;
    gs_addr = 4'(ldlcd_pkg::ADDR_ORIGIN);
    for (int s = 0; s < ldlcd_pkg::SLOTS; s++) begin
      stage[s] = '0;
      shown[s] = '0;
    end
  endfunction

  function automatic void store_gs();
    int dst, src;
    logic b;
    if (!fctl[ldlcd_pkg::POKER_BIT]) begin
      if (gs_addr < ldlcd_pkg::SLOTS) stage[gs_addr] = shreg;
      return;
    end
    for (int s = 0; s < ldlcd_pkg::SLOTS; s++) begin
      for (int j = 0; j < 3; j++) begin
        dst = 32 + gs_addr - 16 * j;
        src = 3 * s + 2 - j;
        b = (src < ldlcd_pkg::WORD_BITS) ? shreg[src] : 1'b0;
        stage[s][dst] = b;
      end
    end
  endfunction

  function automatic status_t predict_status(logic sbit, logic lat, logic [5:0] view);
    status_t r;
    ldlcd_pkg::cmd_t c;
    int slot, col;
    c = ldlcd_pkg::CMD_NONE;
    if (lat) begin
      if (pulse_len != 5'd31) pulse_len++;
    end else begin
      case (pulse_len)
        5'd0: c = ldlcd_pkg::CMD_NONE;
        5'd1: begin
          c = ldlcd_pkg::CMD_WRTGS; store_gs(); gs_addr = gs_addr - 4'd1;
        end
        5'd3: begin
          c = ldlcd_pkg::CMD_LATGS; store_gs(); shown = stage;
          gs_addr = 4'(ldlcd_pkg::ADDR_ORIGIN); lines++;
        end
        5'd5: begin
          c = ldlcd_pkg::CMD_WRTFC; fctl = shreg; gs_addr = 4'(ldlcd_pkg::ADDR_ORIGIN);
        end
        5'd7: begin
          c = ldlcd_pkg::CMD_LINERST; store_gs(); shown = stage;
          lines = '0; gs_addr = 4'(ldlcd_pkg::ADDR_ORIGIN);
        end
        5'd11: c = ldlcd_pkg::CMD_READFC;
        5'd13: begin
          c = ldlcd_pkg::CMD_TMGRST; gs_addr = 4'(ldlcd_pkg::ADDR_ORIGIN); lines = '0;
        end
        5'd15: c = ldlcd_pkg::CMD_FCWRTEN;
        default: c = ldlcd_pkg::CMD_INVALID;
      endcase
      pulse_len = '0;
    end
    shreg = {shreg[ldlcd_pkg::WORD_BITS-2:0], sbit};
    slot = view / 3;
    col = view % 3;
    r.cmd = c;
    r.conflict = fctl[ldlcd_pkg::POKER_BIT] &&
                 (!fctl[ldlcd_pkg::XREF_BIT] || !fctl[ldlcd_pkg::ESPWM_BIT]);
    r.ctl = fctl;
    r.addr = gs_addr;
    r.lines = lines;
    r.dword = (slot < ldlcd_pkg::SLOTS) ? shown[slot][16*col +: 16] : 16'd0;
    return r;
  endfunction

  task automatic send_beat(logic sbit, logic lat, logic [5:0] view);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    serial_bit <= sbit;
    latch_level <= lat;
    view_word <= view;
    @(posedge clk);
    while (full) @(posedge clk);
    status_q.push_back(predict_status(sbit, lat, view));
    beats_in++;
  endtask

  // Pulse of the given length carrying random data, then one low beat.
  task automatic send_pulse(int len);
    for (int i = 0; i < len; i++)
      send_beat(1'($urandom_range(0, 1)), 1'b1, 6'($urandom_range(0, 63)));
    send_beat(1'($urandom_range(0, 1)), 1'b0, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_word(ldlcd_pkg::word_t w);
    for (int i = ldlcd_pkg::WORD_BITS - 1; i >= 0; i--)
      send_beat(w[i], 1'b0, 6'($urandom_range(0, 63)));
  endtask

  // Result checker. The consumer stalls in random bursts until the calm phase.
  always @(posedge clk) begin
    status_t got, want;
    if (!rst) begin
      if (calm) begin
        pop <= 1;
      end else if (pop_hold > 0) begin
        pop <= 0;
        pop_hold <= pop_hold - 1;
      end else if ($urandom_range(0, 5) == 0) begin
        pop <= 0;
        pop_hold <= $urandom_range(0, 5);
      end else begin
        pop <= 1;
      end
      if (pop && !empty) begin
        got = '{command_done, mode_conflict, control_word, slot_address, line_count,
                display_word};
        beats_out++;
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat %h", got);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch beat %0d: exp %h got %h", beats_out, want, got);
          end
          if (want.cmd <= 8) cmd_seen[want.cmd]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    status_t got_first;
    int lens[10] = '{1, 3, 5, 7, 11, 13, 15, 2, 31, 40};
    int len, pick;
    ldlcd_pkg::word_t w;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed table: reset state, extremes of the view and the ports.
    row = '{1'b0, 1'b0, 6'd0, 1'b1,
            '{4'(ldlcd_pkg::CMD_NONE), 1'b0, 48'd0, 4'd15, 16'd0, 16'd0}};
    rows.push_back(row);
    row = '{1'b1, 1'b0, 6'd47, 1'b1,
            '{4'(ldlcd_pkg::CMD_NONE), 1'b0, 48'd0, 4'd15, 16'd0, 16'd0}};
    rows.push_back(row);
    row = '{1'b1, 1'b0, 6'd63, 1'b1,
            '{4'(ldlcd_pkg::CMD_NONE), 1'b0, 48'd0, 4'd15, 16'd0, 16'd0}};
    rows.push_back(row);
    row = '{1'b0, 1'b1, 6'd2, 1'b0, '0};
    rows.push_back(row);
    // A one-beat pulse ends: grayscale write, address steps down.
    row = '{1'b1, 1'b0, 6'd0, 1'b1,
            '{4'(ldlcd_pkg::CMD_WRTGS), 1'b0, 48'd0, 4'd14, 16'd0, 16'd0}};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_beat(rows[i].sbit, rows[i].lat, rows[i].view);
      if (rows[i].has_exp && status_q[$] !== rows[i].exp) begin
        errors++;
        $display("Directed row %0d: predictor %h table %h", i, status_q[$], rows[i].exp);
      end
    end
    foreach (lens[i]) send_pulse(lens[i]);

    // Random part: mostly frames of grayscale data with latches, plus control
    // words that toggle poker, auto-refresh and spectrum bits.
    while (beats_in < 1200) begin
      if (beats_in > 1000) calm = 1;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        w = 48'({$urandom, $urandom});
        if ($urandom_range(0, 1)) begin
          w[ldlcd_pkg::XREF_BIT] = 1'($urandom_range(0, 1));
          w[ldlcd_pkg::ESPWM_BIT] = 1'($urandom_range(0, 1));
        end
        send_word(w);
        send_pulse(5);
      end else if (pick < 7) begin
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
          send_word(48'({$urandom, $urandom}));
          send_pulse(1);
        end
        len = $urandom_range(0, 1) ? 3 : 7;
        send_pulse(len);
      end else if (pick == 7) begin
        send_pulse(lens[$urandom_range(0, 9)]);
      end else begin
        len = $urandom_range(0, 33);
        for (int i = 0; i < 20; i++)
          send_beat(1'($urandom_range(0, 1)), (i < len), 6'($urandom_range(0, 63)));
      end
    end
    push <= 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Pushed %0d beats, checked %0d results; wrtgs %0d latgs %0d wrtfc %0d",
             beats_in, beats_out, cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("linereset %0d tmgrst %0d readfc %0d fcwrten %0d invalid %0d",
             cmd_seen[4], cmd_seen[6], cmd_seen[5], cmd_seen[7], cmd_seen[8]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/ldlcd_pkg.sv
design/ldlcd_front.sv
design/ldlcd_queue.sv
design/ldlcd_back.sv
design/led_driver_latch_command_decoder_unit.sv
test/testbench.sv
